// ===== hw/rtl/apgc_pkg.sv =====
// shared types, constants and codes of the audio peak gain calibrator
`timescale 1ns / 1ps
package apgc_pkg;

	localparam int LOG_FRAC_BITS = 8;
	localparam int LOG_W = 5 + LOG_FRAC_BITS;
	localparam int LOG_CNT_W = (LOG_FRAC_BITS > 1) ? $clog2(LOG_FRAC_BITS) : 1;
	localparam int DIV_W = 22;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int SENS_W = LOG_W + 10;

	localparam logic [1:0] REG_CAL_MIN = 2'd0;
	localparam logic [1:0] REG_CAL_MAX = 2'd1;
	localparam logic [1:0] REG_DURATION = 2'd2;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic action;
		logic signed [15:0] sample;
		logic [31:0] time_ms;
	} in_t;

	typedef struct packed {
		logic [14:0] amplitude;
		logic [14:0] peak;
		logic [6:0] secs_left;
		logic [6:0] bar_level;
		logic [1:0] meter_zone;
		logic gain_ready;
		logic [9:0] gain_tenths;
		logic done_res;
		logic [7:0] sensitivity;
		logic [1:0] noise_gate;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REM,
		S_SCALE,
		S_BAR,
		S_GAIN,
		S_LOGA,
		S_LOGB,
		S_OUT
	} state_t;

endpackage

// ===== hw/rtl/apgc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module apgc_div import apgc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_W-1:0] dividend,
	input logic [DIV_W-1:0] divisor,
	output logic done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_W:0] shifted;
	logic [DIV_W:0] trial;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial[DIV_W]) begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/apgc_log.sv =====
// iterative fixed-point log2: bit-serial normalize, then one squaring per fraction bit
`timescale 1ns / 1ps
module apgc_log import apgc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] value,
	output logic done,
	output logic [LOG_W-1:0] result
);

	logic [31:0] m_q;
	logic [4:0] k_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [LOG_CNT_W-1:0] cnt_q;
	logic norm_q;
	logic busy_q;
	logic done_q;
	logic [63:0] prod;
	logic [32:0] sq;

	assign prod = 64'(m_q) * 64'(m_q);
	assign sq = prod[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			norm_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				norm_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (norm_q) begin
					if (m_q[31] || k_q == 5'd0) begin
						norm_q <= 1'b0;
					end
				end else begin
					if (cnt_q == LOG_CNT_W'(LOG_FRAC_BITS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= value;
			k_q <= 5'd31;
			frac_q <= '0;
		end else if (busy_q) begin
			if (norm_q) begin
				if (!(m_q[31] || k_q == 5'd0)) begin
					m_q <= {m_q[30:0], 1'b0};
					k_q <= k_q - 1'b1;
				end
			end else if (sq[32]) begin
				m_q <= sq[32:1];
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b1};
			end else begin
				m_q <= sq[31:0];
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign result = {k_q, frac_q};

endmodule

// ===== hw/rtl/audio_peak_gain_calibrator_core.sv =====
// top level of the audio peak gain calibrator
// channel  | direction | handshake           | payload
// in       | into core | in_valid / in_stall   | in_data (in_t)
// out      | from core | out_valid / out_stall | out_data (out_t)
// cfg      | into core | cfg_we              | cfg_idx, cfg_data
// a start transaction, or a sample while idle, is taken without leaving S_IDLE
// a sample while active runs four divisions in the shared divider and then loads the result,
// plus up to two log2 evaluations in the log unit on the final sample
// in_stall is high while the sequencer works on a sample
// one output register lets the next transaction in while a result waits
// arst_n clears control state and the calibration registers
`timescale 1ns / 1ps
module audio_peak_gain_calibrator_core import apgc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data
);

	state_t state_q, state_d;

	logic signed [15:0] cal_min_q, cal_max_q;
	logic [15:0] dur_q;
	logic active_q;
	logic [14:0] peak_q;
	logic signed [15:0] center_q, half_q;
	logic [31:0] start_q;
	logic [14:0] amp_q;
	logic done_q;
	logic [16:0] rem_dvd_q;
	logic [6:0] rem_q;
	logic [DIV_W-1:0] scale_q;
	logic [6:0] bar_q;
	logic [9:0] gain_q;
	logic [LOG_W-1:0] la_q, lb_q;
	logic issued_q;
	logic out_valid_q;
	out_t out_q;

	logic accept;
	logic signed [16:0] sum, span, sum_adj, span_adj;
	logic signed [16:0] dev;
	logic [16:0] mag;
	logic [14:0] amp_new, peak_new;
	logic [31:0] elapsed;
	logic done_new;
	logic [16:0] rem_dvd_new;

	logic div_start, div_done, log_start, log_done;
	logic [DIV_W-1:0] div_a, div_b, div_q;
	logic [31:0] log_v;
	logic [LOG_W-1:0] log_r;
	logic do_log;
	logic load_out;

	logic signed [LOG_W:0] ldiff;
	logic signed [SENS_W-1:0] sens_full;
	logic [7:0] sens;
	out_t res;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign sum = 17'(cal_min_q) + 17'(cal_max_q);
	assign span = 17'(cal_max_q) - 17'(cal_min_q);
	assign sum_adj = sum + 17'(sum[16]);
	assign span_adj = span + 17'(span[16]);

	assign dev = 17'(in_data.sample) - 17'(center_q);
	assign mag = dev[16] ? 17'(-dev) : 17'(dev);
	assign amp_new = (mag > 17'd32767) ? 15'd32767 : mag[14:0];
	assign peak_new = (amp_new > peak_q) ? amp_new : peak_q;
	assign elapsed = in_data.time_ms - start_q;
	assign done_new = (elapsed >= {16'd0, dur_q});
	assign rem_dvd_new = done_new ? 17'd0 :
		(17'(dur_q) - 17'(elapsed[15:0]) + 17'd999);

	assign do_log = done_q && (peak_q >= 15'd5) && (half_q > 16'sd0);
	assign load_out = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q <= 16'sd0;
			cal_max_q <= 16'sd32767;
			dur_q <= 16'd3000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CAL_MIN: cal_min_q <= cfg_data;
				REG_CAL_MAX: cal_max_q <= cfg_data;
				REG_DURATION: dur_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			active_q <= 1'b0;
			peak_q <= '0;
			center_q <= '0;
			half_q <= '0;
			start_q <= '0;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (in_data.action == ACT_START) begin
					center_q <= sum_adj[16:1];
					half_q <= span_adj[16:1];
					peak_q <= '0;
					start_q <= in_data.time_ms;
					active_q <= 1'b1;
				end else if (active_q) begin
					peak_q <= peak_new;
					if (done_new) begin
						active_q <= 1'b0;
					end
				end
			end
			if (div_start || log_start) begin
				issued_q <= 1'b1;
			end else if (div_done || log_done) begin
				issued_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amp_q <= amp_new;
			done_q <= done_new;
			rem_dvd_q <= rem_dvd_new;
		end
		if (div_done) begin
			case (state_q)
				S_REM: rem_q <= div_q[6:0];
				S_SCALE: scale_q <= div_q;
				S_BAR: bar_q <= (div_q > DIV_W'(100)) ? 7'd100 : div_q[6:0];
				S_GAIN: gain_q <= (div_q > DIV_W'(640)) ? 10'd640 : div_q[9:0];
				default: ;
			endcase
		end
		if (log_done) begin
			if (state_q == S_LOGA) begin
				la_q <= log_r;
			end else begin
				lb_q <= log_r;
			end
		end
		if (load_out) begin
			out_q <= res;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept && in_data.action == ACT_SAMPLE && active_q) state_d = S_REM;
			S_REM: if (div_done) state_d = S_SCALE;
			S_SCALE: if (div_done) state_d = S_BAR;
			S_BAR: if (div_done) state_d = S_GAIN;
			S_GAIN: if (div_done) state_d = do_log ? S_LOGA : S_OUT;
			S_LOGA: if (log_done) state_d = S_LOGB;
			S_LOGB: if (log_done) state_d = S_OUT;
			S_OUT: if (load_out) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		log_start = 1'b0;
		div_a = '0;
		div_b = '0;
		log_v = '0;
		unique case (state_q)
			S_REM: begin
				div_start = !issued_q;
				div_a = DIV_W'(rem_dvd_q);
				div_b = DIV_W'(1000);
			end
			S_SCALE: begin
				div_start = !issued_q;
				div_a = DIV_W'(peak_q) * DIV_W'(85);
				div_b = DIV_W'(100);
			end
			S_BAR: begin
				div_start = !issued_q;
				div_a = DIV_W'(amp_q) * DIV_W'(100);
				div_b = scale_q;
			end
			S_GAIN: begin
				div_start = !issued_q;
				div_a = DIV_W'(half_q[14:0]) * DIV_W'(28) + DIV_W'(peak_q);
				div_b = DIV_W'({peak_q, 1'b0});
			end
			S_LOGA: begin
				log_start = !issued_q;
				log_v = 32'(half_q[14:0]) * 32'd28;
			end
			S_LOGB: begin
				log_start = !issued_q;
				log_v = 32'(peak_q) * 32'd5;
			end
			S_IDLE, S_OUT: ;
			default: ;
		endcase
	end

	assign ldiff = $signed({1'b0, la_q}) - $signed({1'b0, lb_q});
	assign sens_full = (SENS_W'(ldiff) * SENS_W'(255) + SENS_W'(4 << LOG_FRAC_BITS))
		>>> (LOG_FRAC_BITS + 3);
	assign sens = (ldiff <= 0) ? 8'd0 :
		((sens_full > SENS_W'(255)) ? 8'd255 : sens_full[7:0]);

	always_comb begin
		res = '0;
		res.amplitude = amp_q;
		res.peak = peak_q;
		res.secs_left = done_q ? 7'd0 : rem_q;
		if (peak_q > 15'd10) begin
			res.bar_level = bar_q;
		end else begin
			res.bar_level = (amp_q != 15'd0) ? 7'd50 : 7'd0;
		end
		if (res.bar_level < 7'd50) begin
			res.meter_zone = 2'd0;
		end else if (res.bar_level < 7'd80) begin
			res.meter_zone = 2'd1;
		end else begin
			res.meter_zone = 2'd2;
		end
		if (half_q > 16'sd0 && peak_q > 15'd5) begin
			res.gain_ready = 1'b1;
			res.gain_tenths = gain_q;
		end
		res.done_res = done_q;
		if (done_q) begin
			if (peak_q < 15'd5) begin
				res.sensitivity = 8'd255;
				res.noise_gate = 2'd0;
			end else begin
				res.noise_gate = 2'd3;
				res.sensitivity = do_log ? sens : 8'd0;
			end
		end
	end

	apgc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_a),
		.divisor(div_b),
		.done(div_done),
		.quotient(div_q)
	);

	apgc_log u_log (
		.clk(clk),
		.arst_n(arst_n),
		.start(log_start),
		.value(log_v),
		.done(log_done),
		.result(log_r)
	);

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== hw/rtl/apgc_checker.sv =====
// port-level checks of the calibrator core, bound to the top level
`timescale 1ns / 1ps
module apgc_checker import apgc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transaction changed");

	a_not_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |->
		out_data.sensitivity == 8'd0 && out_data.noise_gate == 2'd0)
		else $error("sensitivity or gate set before done");

	a_meter_zone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.bar_level <= 7'd100 &&
		((out_data.meter_zone == 2'd0) == (out_data.bar_level < 7'd50)) &&
		((out_data.meter_zone == 2'd2) == (out_data.bar_level >= 7'd80)))
		else $error("meter zone does not match bar level");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.gain_tenths <= 10'd640 &&
		(out_data.gain_ready || out_data.gain_tenths == 10'd0))
		else $error("gain preview out of range");

endmodule

bind audio_peak_gain_calibrator_core apgc_checker u_apgc_checker (.*);

// ===== bench/apgc_result_checker.sv =====
// checker for the audio peak gain calibrator: predicts results and compares them
`timescale 1ns / 1ps
module apgc_result_checker import apgc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_t in_data,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data,
	output int errors,
	output int pending
);

	logic signed [15:0] cal_min_q, cal_max_q;
	logic [15:0] dur_q;
	logic running;
	logic [14:0] peak_q;
	int center_q, half_q;
	logic [31:0] start_q;
	out_t expected_q[$];

	function automatic longint log2_q8(input logic [31:0] v);
		int k;
		longint unsigned m;
		longint fr;
		k = 31;
		fr = 0;
		while (k > 0 && v[k] == 1'b0)
			k--;
		m = longint'(v) << (31 - k);
		for (int i = 0; i < LOG_FRAC_BITS; i++) begin
			m = (m * m) >> 31;
			fr = fr << 1;
			if (m >= 64'h1_0000_0000) begin
				fr = fr | 1;
				m = m >> 1;
			end
		end
		return (longint'(k) << LOG_FRAC_BITS) | fr;
	endfunction

	task automatic predict_transaction(input in_t t);
		out_t r;
		logic [31:0] elapsed;
		int diff, amp, bar, scale;
		longint tn, lg, s;
		if (t.action == ACT_START) begin
			center_q = (int'(cal_min_q) + int'(cal_max_q)) / 2;
			half_q = (int'(cal_max_q) - int'(cal_min_q)) / 2;
			peak_q = '0;
			start_q = t.time_ms;
			running = 1'b1;
			return;
		end
		if (!running)
			return;
		r = '0;
		elapsed = t.time_ms - start_q;
		diff = int'(t.sample) - center_q;
		if (diff < 0)
			diff = -diff;
		amp = diff > 32767 ? 32767 : diff;
		if (amp > peak_q)
			peak_q = amp[14:0];
		r.amplitude = amp[14:0];
		r.peak = peak_q;
		if (elapsed < {16'd0, dur_q})
			r.secs_left = 7'((int'(dur_q) - int'(elapsed) + 999) / 1000);
		if (peak_q > 10) begin
			scale = (int'(peak_q) * 85) / 100;
			bar = (amp * 100) / scale;
			if (bar > 100)
				bar = 100;
		end else begin
			bar = amp > 0 ? 50 : 0;
		end
		r.bar_level = bar[6:0];
		r.meter_zone = bar < 50 ? 2'd0 : (bar < 80 ? 2'd1 : 2'd2);
		if (half_q > 0 && peak_q > 5) begin
			tn = (28 * longint'(half_q) + peak_q) / (2 * longint'(peak_q));
			r.gain_ready = 1'b1;
			r.gain_tenths = tn > 640 ? 10'd640 : tn[9:0];
		end
		if (elapsed >= {16'd0, dur_q}) begin
			r.done_res = 1'b1;
			running = 1'b0;
			if (peak_q < 5) begin
				r.sensitivity = 8'd255;
			end else begin
				r.noise_gate = 2'd3;
				if (half_q > 0) begin
					lg = log2_q8(32'(28 * half_q)) - log2_q8(32'(5 * int'(peak_q)));
					if (lg > 0) begin
						s = (255 * lg + (longint'(4) << LOG_FRAC_BITS))
							/ (longint'(8) << LOG_FRAC_BITS);
						r.sensitivity = s > 255 ? 8'd255 : s[7:0];
					end
				end
			end
		end
		expected_q.push_back(r);
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			cal_min_q <= 16'sd0;
			cal_max_q <= 16'sd32767;
			dur_q <= 16'd3000;
			running = 1'b0;
			peak_q = '0;
			center_q = 0;
			half_q = 0;
			start_q = '0;
			errors = 0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CAL_MIN: cal_min_q <= cfg_data;
					REG_CAL_MAX: cal_max_q <= cfg_data;
					REG_DURATION: dur_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected transaction expected none actual %h",
						$time, out_data);
					errors++;
				end else begin
					e = expected_q.pop_front();
					check_field("amplitude", e.amplitude, out_data.amplitude);
					check_field("peak", e.peak, out_data.peak);
					check_field("secs_left", e.secs_left, out_data.secs_left);
					check_field("bar_level", e.bar_level, out_data.bar_level);
					check_field("meter_zone", e.meter_zone, out_data.meter_zone);
					check_field("gain_ready", e.gain_ready, out_data.gain_ready);
					check_field("gain_tenths", e.gain_tenths, out_data.gain_tenths);
					check_field("done_res", e.done_res, out_data.done_res);
					check_field("sensitivity", e.sensitivity, out_data.sensitivity);
					check_field("noise_gate", e.noise_gate, out_data.noise_gate);
				end
			end
			if (in_valid && !in_stall)
				predict_transaction(in_data);
			pending = expected_q.size();
		end
	end

endmodule

// ===== bench/audio_peak_gain_calibrator_core_test.sv =====
// testbench top of the audio peak gain calibrator: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module audio_peak_gain_calibrator_core_test;
	import apgc_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_we;
	in_t in_data;
	out_t out_data;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_data;
	int errors, pending;
	int sent_cnt, idle_cnt;
	logic calm, hold_req;
	int cmin, cmax;
	logic [15:0] dur;

	audio_peak_gain_calibrator_core dut (.*);

	apgc_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic send(input logic act, input int smp, input logic [31:0] t);
		int g;
		g = draw_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{action: act, sample: 16'(smp), time_ms: t};
		do @(posedge clk); while (in_stall);
		sent_cnt++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input int mn, input int mx, input int d);
		settle();
		cmin = mn;
		cmax = mx;
		dur = 16'(d);
		write_reg(REG_CAL_MIN, 16'(mn));
		write_reg(REG_CAL_MAX, 16'(mx));
		write_reg(REG_DURATION, 16'(d));
		cfg_we <= 1'b0;
	endtask

	function automatic int near_center(input int spread);
		int v;
		v = (cmin + cmax) / 2 + $urandom_range(0, 2 * spread) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	// one calibration window: start, n samples, the last one at or past the end
	task automatic run_window(input int n, input int spread);
		logic [31:0] t0, t;
		int smp;
		t0 = $urandom;
		send(ACT_START, $urandom, t0);
		for (int i = 1; i <= n; i++) begin
			if (i == n)
				t = t0 + dur + $urandom_range(0, 2);
			else
				t = t0 + (int'(dur) * i) / n;
			smp = ($urandom_range(0, 9) == 0) ? int'($urandom) : near_center(spread);
			send(ACT_SAMPLE, smp, t);
		end
	endtask

	initial begin
		logic [31:0] t0;
		int mn, mx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_CAL_MIN;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		sent_cnt = 0;
		cmin = 0;
		cmax = 32767;
		dur = 16'd3000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle sample, extremes, restart, wrap, quiet window
		send(ACT_SAMPLE, 100, 32'd5);
		send(ACT_START, 0, 32'hFFFF_FF00);
		send(ACT_SAMPLE, -32768, 32'hFFFF_FF10);
		send(ACT_SAMPLE, 32767, 32'h0000_0010);
		send(ACT_SAMPLE, 16383, 32'h0000_0100);
		send(ACT_START, 0, 32'd1000);
		send(ACT_SAMPLE, 16390, 32'd1001);
		send(ACT_SAMPLE, 16383, 32'd4000);
		send(ACT_START, 0, 32'd10);
		send(ACT_SAMPLE, 16385, 32'd3009);
		send(ACT_SAMPLE, 16300, 32'd3010);
		send(ACT_START, 0, 32'd50);
		send(ACT_SAMPLE, 0, 32'd40);
		configure(-32768, 32767, 65535);
		run_window(3, 32767);
		configure(32767, -32768, 0);
		send(ACT_START, 0, 32'd0);
		send(ACT_SAMPLE, 1000, 32'd0);
		configure(5, 5, 1);
		run_window(2, 40);
		configure(0, 32767, 2000);
		hold_req = 1'b1;
		calm = 1'b1;
		run_window(6, 20000);
		calm = 1'b0;

		while (sent_cnt < 550) begin
			case ($urandom_range(0, 5))
				0: begin mn = -32768; mx = 32767; end
				1: begin mn = $urandom_range(0, 65535) - 32768; mx = mn; end
				2: begin mn = $urandom_range(0, 65535) - 32768; mx = $urandom_range(0, 65535) - 32768; end
				default: begin
					mn = $urandom_range(0, 32767) - 32768;
					mx = $urandom_range(0, 32767);
				end
			endcase
			configure(mn, mx, ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 6000));
			calm = $urandom_range(0, 3) == 0;
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 9) == 0) begin
					t0 = $urandom;
					send(1'($urandom_range(0, 1)), $urandom, t0);
				end
				run_window($urandom_range(1, 8),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 40000));
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("audio_peak_gain_calibrator_core_test: clean");
		else
			$display("audio_peak_gain_calibrator_core_test: errors");
		$finish;
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (500) @(posedge clk);
				hold_req = 1'b0;
			end
			g = draw_gap();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= 20000) begin
			$display("audio_peak_gain_calibrator_core_test: errors");
			$finish;
		end
	end

	initial idle_cnt = 0;

endmodule
